// File: design/dual_motor_pwm_speed_ramp_unit_defines.svh
// Assertion macros used by the checker file of the motor drive unit.
`ifndef DUAL_MOTOR_PWM_SPEED_RAMP_UNIT_DEFINES_SVH
`define DUAL_MOTOR_PWM_SPEED_RAMP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define DMPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmpr assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define DMPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmpr assertion failed");

`endif

// File: design/dmpr_pkg.sv
// Shared constants, codes and divider handshake types of the motor drive unit.
`default_nettype none
package dmpr_pkg;

    localparam int DUTY_MAX   = 100;
    localparam int PWM_PERIOD = 1000;
    localparam int CMP_SCALE  = 10;

    localparam int DUTY_W = 7;
    localparam int CMP_W  = 10;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 48;
    localparam int DIV_W  = 7;

    // command codes
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // direction codes of a set_speed
    localparam logic [1:0] DIR_FWD = 2'd0;
    localparam logic [1:0] DIR_REV = 2'd1;

    // drive modes
    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_FORWARD = 2'd1;
    localparam logic [1:0] MODE_REVERSE = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_ATTACK    = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: design/dmpr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module dmpr_div
    import dmpr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // dividend bits shift out of the top of r_quo as quotient bits shift in
            r_rem <= fits ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// File: design/dual_motor_pwm_speed_ramp_unit.sv
// Top level: two-motor H-bridge PWM drive with tick-based speed ramp.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tuser: command; tdata: direction, left, right target
//  m_axis    | out       | tdata: four compares, enables, pwm on, ramp busy
//  cfg       | in        | index 0 attack_step, 1 ramp_threshold; 7-bit data
//
// Ticks and stops go straight from evaluation to the result; a set_speed that
// ramps runs the shared serial divider twice (ramp length, then the slower
// motor's step). s_axis is not ready while a command is in work; a result
// waiting on m_axis holds the next one back.
// Reset is synchronous and active low; config writes are taken every cycle.
`default_nettype none
module dual_motor_pwm_speed_ramp_unit
    import dmpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,  // [1:0] direction, [8:2] left_target,
                                                    // [15:9] right_target
    input  wire logic [1:0]        i_s_axis_tuser,  // [1:0] command
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [OUT_W-1:0]       o_m_axis_tdata,  // [9:0] left_fwd_compare,
                                                    // [19:10] right_fwd_compare,
                                                    // [29:20] left_rev_compare,
                                                    // [39:30] right_rev_compare,
                                                    // [40] left_enable, [41] right_enable,
                                                    // [42] fwd_pwm_on, [43] rev_pwm_on,
                                                    // [44] ramp_busy, [47:45] zero
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [DUTY_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [DUTY_W-1:0] DMAX = DUTY_W'(DUTY_MAX);

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
        return (v > DMAX) ? DMAX : v;
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_sum(input logic signed [16:0] v);
        logic [DUTY_W-1:0] res;
        if (v < 17'sd0) res = '0;
        else if (v > $signed({10'd0, DMAX})) res = DMAX;
        else res = v[DUTY_W-1:0];
        return res;
    endfunction

    function automatic logic [CMP_W-1:0] compare_of(input logic [DUTY_W-1:0] d);
        logic [CMP_W:0] p;
        p = (CMP_W+1)'(d) * (CMP_W+1)'(CMP_SCALE);
        return (p > (CMP_W+1)'(PWM_PERIOD)) ? CMP_W'(PWM_PERIOD) : p[CMP_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] mag(input logic signed [DUTY_W:0] v);
        logic [DUTY_W:0] m;
        m = v[DUTY_W] ? (DUTY_W+1)'(-v) : v;
        return m[DUTY_W-1:0];
    endfunction

    logic [2:0]               r_state;
    logic [1:0]               r_cmd;
    logic [1:0]               r_dir;
    logic [DUTY_W-1:0]        r_lt, r_rt;
    logic [DUTY_W-1:0]        r_attack, r_thresh;
    logic [1:0]               r_mode;
    logic [DUTY_W-1:0]        r_lduty, r_rduty;
    logic [DUTY_W-1:0]        r_lstart, r_rstart;
    logic signed [DUTY_W:0]   r_lstep, r_rstep;
    logic [DUTY_W-1:0]        r_lgoal, r_rgoal;
    logic [DUTY_W-1:0]        r_len, r_idx;
    logic                     r_active;
    logic signed [DUTY_W:0]   r_dl, r_dr;
    logic                     r_left_major;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;

    logic [DUTY_W-1:0]        attack_eff;
    logic signed [DUTY_W:0]   dl, dr;
    logic [DUTY_W-1:0]        al, ar;
    logic [DUTY_W-1:0]        idx_nx;
    logic signed [15:0]       lprod, rprod;
    logic [DUTY_W-1:0]        tick_l, tick_r;
    logic [DUTY_W-1:0]        minor_q;
    logic signed [DUTY_W:0]   minor_step, major_step;
    logic                     fwd, rev;
    logic                     in_acc, out_free;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign attack_eff = (r_attack == '0) ? DUTY_W'(1) : r_attack;
    assign dl = $signed({1'b0, r_lt}) - $signed({1'b0, r_lduty});
    assign dr = $signed({1'b0, r_rt}) - $signed({1'b0, r_rduty});
    assign al = mag(dl);
    assign ar = mag(dr);

    // ramp point: start + index * step
    assign idx_nx = r_idx + 1'b1;
    assign lprod  = $signed({1'b0, idx_nx}) * r_lstep;
    assign rprod  = $signed({1'b0, idx_nx}) * r_rstep;
    assign tick_l = clamp_sum(17'(lprod) + $signed({10'd0, r_lstart}));
    assign tick_r = clamp_sum(17'(rprod) + $signed({10'd0, r_rstart}));

    assign minor_q    = div_rsp.quotient;
    assign minor_step = (r_left_major ? r_dr[DUTY_W] : r_dl[DUTY_W])
                        ? -$signed({1'b0, minor_q}) : $signed({1'b0, minor_q});
    assign major_step = (r_left_major ? r_dl[DUTY_W] : r_dr[DUTY_W])
                        ? -$signed({1'b0, attack_eff}) : $signed({1'b0, attack_eff});

    always_comb begin
        div_req = '0;
        if (r_state == S_DIFF) begin
            div_req.start    = !(al < r_thresh && ar < r_thresh);
            div_req.dividend = (al >= ar) ? al : ar;
            div_req.divisor  = attack_eff;
        end else if (r_state == S_DIV1) begin
            div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
            div_req.dividend = r_left_major ? mag(r_dr) : mag(r_dl);
            div_req.divisor  = div_rsp.quotient;
        end
    end

    dmpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= DUTY_W'(5);
            r_thresh <= DUTY_W'(10);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK:    r_attack <= i_cfg_data;
                CFG_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_s_axis_tuser;
            r_dir <= i_s_axis_tdata[1:0];
            r_lt  <= sat_duty(i_s_axis_tdata[8:2]);
            r_rt  <= sat_duty(i_s_axis_tdata[15:9]);
        end
        if (r_state == S_DIFF) begin
            r_dl         <= dl;
            r_dr         <= dr;
            r_left_major <= (al >= ar);
        end
    end

    assign fwd = (r_mode == MODE_FORWARD);
    assign rev = (r_mode == MODE_REVERSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_STOPPED;
            r_lduty     <= '0;
            r_rduty     <= '0;
            r_lstart    <= '0;
            r_rstart    <= '0;
            r_lstep     <= '0;
            r_rstep     <= '0;
            r_lgoal     <= '0;
            r_rgoal     <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_active    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_OUT;
                    if (r_cmd == CMD_STOP ||
                        (r_cmd == CMD_SET && r_dir != DIR_FWD && r_dir != DIR_REV)) begin
                        r_mode   <= MODE_STOPPED;
                        r_lduty  <= '0;
                        r_rduty  <= '0;
                        r_active <= 1'b0;
                        r_idx    <= '0;
                    end else if (r_cmd == CMD_SET) begin
                        // direction change: stop first, ramp starts from zero
                        if (r_mode != r_dir + 2'd1) begin
                            r_mode  <= r_dir + 2'd1;
                            r_lduty <= '0;
                            r_rduty <= '0;
                        end
                        r_active <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= S_DIFF;
                    end else if (r_cmd == CMD_TICK && r_active) begin
                        if (idx_nx >= r_len) begin
                            r_lduty  <= r_lgoal;
                            r_rduty  <= r_rgoal;
                            r_active <= 1'b0;
                            r_idx    <= '0;
                        end else begin
                            r_lduty <= tick_l;
                            r_rduty <= tick_r;
                            r_idx   <= idx_nx;
                        end
                    end
                end
                S_DIFF: begin
                    if (!div_req.start) begin
                        r_lduty <= r_lt;
                        r_rduty <= r_rt;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient == '0) begin
                            r_lduty <= r_lt;
                            r_rduty <= r_rt;
                            r_state <= S_OUT;
                        end else begin
                            r_len   <= div_rsp.quotient;
                            r_state <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_lstep  <= r_left_major ? major_step : minor_step;
                        r_rstep  <= r_left_major ? minor_step : major_step;
                        r_lstart <= r_lduty;
                        r_rstart <= r_rduty;
                        r_lgoal  <= r_lt;
                        r_rgoal  <= r_rt;
                        r_active <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat: loaded from S_OUT, dropped once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {3'b000, r_active, rev, fwd, fwd || rev, fwd || rev,
                           rev ? compare_of(r_rduty) : CMP_W'(0),
                           rev ? compare_of(r_lduty) : CMP_W'(0),
                           fwd ? compare_of(r_rduty) : CMP_W'(0),
                           fwd ? compare_of(r_lduty) : CMP_W'(0)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: design/dmpr_checker.sv
// Port-level checker for the motor drive unit, bound to the top level.
`default_nettype none
`include "dual_motor_pwm_speed_ramp_unit_defines.svh"
module dmpr_checker
    import dmpr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_axis_tvalid,
    input wire logic              o_s_axis_tready,
    input wire logic              o_m_axis_tvalid,
    input wire logic              i_m_axis_tready,
    input wire logic [OUT_W-1:0]  o_m_axis_tdata
);

    logic fwd_on, rev_on;
    logic drive_on;
    logic out_stall;
    logic in_beat;

    assign fwd_on    = o_m_axis_tdata[42];
    assign rev_on    = o_m_axis_tdata[43];
    assign drive_on  = fwd_on || rev_on;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;

    `DMPR_ASSERT_NEXT(a_out_hold, out_stall, $stable(o_m_axis_tdata) && o_m_axis_tvalid)
    `DMPR_ASSERT_NEXT(a_busy_after_accept, in_beat, !o_s_axis_tready)
    `DMPR_ASSERT_NOW(a_one_direction, o_m_axis_tvalid, !(fwd_on && rev_on))
    `DMPR_ASSERT_NOW(a_enables_follow, o_m_axis_tvalid, o_m_axis_tdata[41:40] == {2{drive_on}})
    `DMPR_ASSERT_NOW(a_idle_compares, o_m_axis_tvalid && !fwd_on, o_m_axis_tdata[19:0] == 20'd0)

endmodule

bind dual_motor_pwm_speed_ramp_unit dmpr_checker u_dmpr_checker (.*);
`default_nettype wire
